FILE: sv/ebt_pkg.sv
// shared types, constants and character-class helpers for the expression byte tokenizer
// no dependencies; used by ebt_scan and expression_byte_tokenizer_unit
package ebt_pkg;

   // length limit of a number or identifier run, never above what token_length carries
   localparam int MAX_TOKEN_LEN = 63;
   localparam int LEN_W         = 6;
   localparam int LEN_CAP_INT   = (MAX_TOKEN_LEN > 63) ? 63 : MAX_TOKEN_LEN;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

   localparam int START_W = 32;

   // result queue depth and derived widths
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // keyword matcher progress codes
   localparam logic [2:0] KW_MATCHED = 3'd5;
   localparam logic [2:0] KW_DEAD    = 3'd7;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5a;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7a;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_T     = 8'h74;

   typedef enum logic [3:0] {
      KIND_NUMBER  = 4'd0,
      KIND_IDENT   = 4'd1,
      KIND_PRINT   = 4'd2,
      KIND_PLUS    = 4'd3,
      KIND_MINUS   = 4'd4,
      KIND_MULT    = 4'd5,
      KIND_DIV     = 4'd6,
      KIND_ASSIGN  = 4'd7,
      KIND_SEMI    = 4'd8,
      KIND_LPAREN  = 4'd9,
      KIND_RPAREN  = 4'd10,
      KIND_END     = 4'd11,
      KIND_INVALID = 4'd12
   } tok_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_NUMBER = 2'd1,
      MODE_IDENT  = 2'd2
   } scan_mode_type;

   typedef struct packed {
      tok_kind_type        kind;
      logic [START_W-1:0]  start;
      logic [LEN_W-1:0]    length;
      logic                too_long;
      logic                last;
   } token_type;

   // up to two tokens per byte: the closed run first, then the byte's own token
   typedef struct packed {
      logic      run_valid;
      token_type run_tok;
      logic      own_valid;
      token_type own_tok;
   } scan_out_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // expected character of "print" at each match position
   function automatic logic [7:0] keyword_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = CH_P;
         3'd1:    ch = CH_R;
         3'd2:    ch = CH_I;
         3'd3:    ch = CH_N;
         default: ch = CH_T;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] keyword_next(input logic [2:0] kw, input logic [7:0] c);
      logic [2:0] nxt;
      if ((kw < KW_MATCHED) && (c == keyword_char(kw))) begin
         nxt = kw + 3'd1;
      end else begin
         nxt = KW_DEAD;
      end
      return nxt;
   endfunction

endpackage

FILE: sv/expression_byte_tokenizer_unit.sv
// top level of the expression byte tokenizer: input register, scanner, result queue
// depends on ebt_pkg and ebt_scan
//
//  channel | direction | transfer        | payload
//  --------+-----------+-----------------+------------------------------------------
//  req     | in        | one source byte | tdata[7:0] char_in
//  rsp     | out       | one token       | tdata start/length/too_long, tuser kind,
//          |           |                 | tlast last result of its byte
//
// one source byte is taken per cycle while req_tready is high; the byte is registered,
// then the scanner updates the run state and writes zero, one or two tokens into an
// eight-entry queue; rsp offers the token at the head of the queue, which drains one
// token per cycle unless rsp stalls, so a byte that yields two tokens takes two
// output transfers, and req_tready drops only while the queue is close to full;
// reset is synchronous and returns the scanner to idle with offset zero and empties
// the queue; a stall on rsp only fills the queue and never loses a token
module expression_byte_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] token_start, [37:32] token_length,
                                    // [38] too_long, [39] zero
   output logic [3:0]  rsp_tuser,   // [3:0] token_kind
   output logic        rsp_tlast    // last token of its byte
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       req_fire;

   ebt_pkg::scan_out_type scan_out;

   // result queue
   ebt_pkg::token_type                 fifo_ff [ebt_pkg::FIFO_DEPTH];
   logic [ebt_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ebt_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ebt_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic [ebt_pkg::FIFO_PTR_W-1:0]     own_slot;
   logic [1:0]                         push_cnt;
   logic                               pop;
   ebt_pkg::token_type                 head;

   // room for the byte in the input register plus the new one, two tokens each
   localparam logic [ebt_pkg::FIFO_CNT_W-1:0] ROOM_BUSY =
      ebt_pkg::FIFO_CNT_W'(ebt_pkg::FIFO_DEPTH - 4);
   localparam logic [ebt_pkg::FIFO_CNT_W-1:0] ROOM_FREE =
      ebt_pkg::FIFO_CNT_W'(ebt_pkg::FIFO_DEPTH - 2);

   assign req_tready  = in_valid_ff ? (count_ff <= ROOM_BUSY) : (count_ff <= ROOM_FREE);
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire;   // the scanner always consumes the register next cycle

   ebt_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .step_in  (in_valid_ff),
      .char_in  (in_char_ff),
      .scan_out (scan_out)
   );

   // queue bookkeeping
   always_comb begin
      push_cnt  = {1'b0, scan_out.run_valid} + {1'b0, scan_out.own_valid};
      pop       = rsp_tvalid && rsp_tready;
      own_slot  = wr_ptr_ff + ebt_pkg::FIFO_PTR_W'(scan_out.run_valid);
      wr_ptr_in = wr_ptr_ff + ebt_pkg::FIFO_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + ebt_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + ebt_pkg::FIFO_CNT_W'(push_cnt) - ebt_pkg::FIFO_CNT_W'(pop);
   end

   // output side
   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {1'b0, head.too_long, head.length, head.start};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_tdata;
      end
      if (scan_out.run_valid) begin
         fifo_ff[wr_ptr_ff] <= scan_out.run_tok;
      end
      if (scan_out.own_valid) begin
         fifo_ff[own_slot] <= scan_out.own_tok;
      end
   end

endmodule

FILE: sv/ebt_scan.sv
// per-byte scanner: character classifier, run state and token building
// depends on ebt_pkg
module ebt_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_in,
   input  logic [7:0]            char_in,
   output ebt_pkg::scan_out_type scan_out
);

   ebt_pkg::scan_mode_type               mode_ff, mode_in;
   logic [ebt_pkg::LEN_W-1:0]            len_ff, len_in;
   logic                                 over_ff, over_in;
   logic [2:0]                           kw_ff, kw_in;
   logic [ebt_pkg::START_W-1:0]          start_ff, start_in;
   logic [ebt_pkg::START_W-1:0]          offset_ff, offset_in;

   logic c_digit, c_letter, c_space, c_cont;
   ebt_pkg::tok_kind_type op_kind;
   logic                  c_op;

   always_comb begin
      c_digit  = ebt_pkg::is_digit(char_in);
      c_letter = ebt_pkg::is_letter(char_in);
      c_space  = ebt_pkg::is_space(char_in);
      c_cont   = ((mode_ff == ebt_pkg::MODE_NUMBER) && c_digit) ||
                 ((mode_ff == ebt_pkg::MODE_IDENT) &&
                  (c_letter || c_digit || (char_in == ebt_pkg::CH_UNDER)));
   end

   always_comb begin
      c_op    = 1'b1;
      op_kind = ebt_pkg::KIND_INVALID;
      case (char_in)
         ebt_pkg::CH_PLUS:  op_kind = ebt_pkg::KIND_PLUS;
         ebt_pkg::CH_MINUS: op_kind = ebt_pkg::KIND_MINUS;
         ebt_pkg::CH_STAR:  op_kind = ebt_pkg::KIND_MULT;
         ebt_pkg::CH_SLASH: op_kind = ebt_pkg::KIND_DIV;
         ebt_pkg::CH_EQ:    op_kind = ebt_pkg::KIND_ASSIGN;
         ebt_pkg::CH_SEMI:  op_kind = ebt_pkg::KIND_SEMI;
         ebt_pkg::CH_LPAR:  op_kind = ebt_pkg::KIND_LPAREN;
         ebt_pkg::CH_RPAR:  op_kind = ebt_pkg::KIND_RPAREN;
         default:           c_op = 1'b0;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      len_in    = len_ff;
      over_in   = over_ff;
      kw_in     = kw_ff;
      start_in  = start_ff;
      offset_in = offset_ff + ebt_pkg::START_W'(1);
      scan_out  = '0;

      // closed run token
      scan_out.run_tok.kind     = (mode_ff == ebt_pkg::MODE_NUMBER) ? ebt_pkg::KIND_NUMBER :
                                  (kw_ff == ebt_pkg::KW_MATCHED)    ? ebt_pkg::KIND_PRINT :
                                                                      ebt_pkg::KIND_IDENT;
      scan_out.run_tok.start    = start_ff;
      scan_out.run_tok.length   = len_ff;
      scan_out.run_tok.too_long = over_ff;
      scan_out.own_tok.kind     = ebt_pkg::KIND_INVALID;
      scan_out.own_tok.start    = offset_ff;
      scan_out.own_tok.last     = 1'b1;

      if (c_cont) begin
         // run continues, no token
         if (len_ff < ebt_pkg::LEN_CAP) begin
            len_in = len_ff + ebt_pkg::LEN_W'(1);
         end else begin
            over_in = 1'b1;
         end
         if (mode_ff == ebt_pkg::MODE_IDENT) begin
            kw_in = ebt_pkg::keyword_next(kw_ff, char_in);
         end
      end else begin
         scan_out.run_valid = (mode_ff != ebt_pkg::MODE_IDLE);
         mode_in            = ebt_pkg::MODE_IDLE;
         if (c_space) begin
            // skipped
         end else if (c_digit || c_letter) begin
            mode_in  = c_digit ? ebt_pkg::MODE_NUMBER : ebt_pkg::MODE_IDENT;
            start_in = offset_ff;
            len_in   = ebt_pkg::LEN_W'(1);
            over_in  = 1'b0;
            kw_in    = c_digit ? 3'd0 : ebt_pkg::keyword_next(3'd0, char_in);
         end else if (char_in == ebt_pkg::CH_NUL) begin
            scan_out.own_valid    = 1'b1;
            scan_out.own_tok.kind = ebt_pkg::KIND_END;
         end else if (c_op) begin
            scan_out.own_valid      = 1'b1;
            scan_out.own_tok.kind   = op_kind;
            scan_out.own_tok.length = ebt_pkg::LEN_W'(1);
         end else begin
            scan_out.own_valid = 1'b1;
         end
      end
      scan_out.run_tok.last = !scan_out.own_valid;

      if (!step_in) begin
         scan_out.run_valid = 1'b0;
         scan_out.own_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ebt_pkg::MODE_IDLE;
         len_ff    <= '0;
         over_ff   <= 1'b0;
         kw_ff     <= '0;
         start_ff  <= '0;
         offset_ff <= '0;
      end else if (step_in) begin
         mode_ff   <= mode_in;
         len_ff    <= len_in;
         over_ff   <= over_in;
         kw_ff     <= kw_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
      end
   end

endmodule
